// File: hdl/bbar_pkg.sv
// Shared types, codes and helpers for the bit buffer append/read unit.
`default_nettype none
package bbar_pkg;

    localparam int CAP_BYTES_DEF = 256;

    localparam logic [1:0] KIND_APPEND  = 2'd0;
    localparam logic [1:0] KIND_RD_BIT  = 2'd1;
    localparam logic [1:0] KIND_RD_BYTE = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WR2
    } t_state;

    function automatic logic [7:0] bit_rev8(input logic [7:0] x);
        logic [7:0] y;
        for (int i = 0; i < 8; i++) begin
            y[i] = x[7 - i];
        end
        return y;
    endfunction

endpackage
`default_nettype wire

// File: hdl/bit_buffer_append_read_unit.sv
// Bit buffer append/read unit: top level with sequencer and bit datapath.
// Execute on the registered byte read; o_valid strobes the cycle after execute.
// A new word is accepted only while idle; an append that crosses a byte boundary takes
// an extra write state, set by the single write port of the byte store.
// Reset clears the fill level and control state; store contents above the fill level are
// never read, so the store itself needs no clearing pass. Results cannot be stalled.
`default_nettype none
module bit_buffer_append_read_unit #(
    parameter int CAP_BYTES = bbar_pkg::CAP_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_value,
    input  wire logic [3:0]  i_bit_count,
    input  wire logic [10:0] i_read_offset,
    output logic             o_valid,
    output logic      [7:0]  o_read_data,
    output logic      [1:0]  o_status,
    output logic      [11:0] o_fill_bits
);

    localparam int AW = (CAP_BYTES > 1) ? $clog2(CAP_BYTES) : 1;
    localparam int FW = $clog2(CAP_BYTES * 8 + 1);
    localparam int CW = ((FW > 11) ? FW : 11) + 1;
    localparam int BW = CW - 3;
    localparam logic [CW-1:0] CAP_BITS = CW'(CAP_BYTES * 8);

    bbar_pkg::t_state r_state;
    bbar_pkg::t_state n_state;

    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;
    logic [1:0]    r_kind;
    logic [7:0]    r_value;
    logic [3:0]    r_count;
    logic [10:0]   r_offset;
    logic [AW-1:0] r_a1;
    logic [7:0]    r_hi;
    logic          r_valid;
    logic [7:0]    r_read_data;
    logic [1:0]    r_status;
    logic [11:0]   r_fill_bits;

    logic          accept;
    logic [CW-1:0] fill_c;
    logic [CW-1:0] in_off_c;
    logic [BW-1:0] a0_c;
    logic [BW-1:0] a1_c;
    logic [7:0]    rd0;
    logic [7:0]    rd1;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;

    logic [CW-1:0] off_c;
    logic [3:0]    cnt;
    logic [2:0]    s_ap;
    logic [15:0]   win;
    logic [7:0]    app;
    logic [7:0]    keep;
    logic [15:0]   merged;
    logic          app_fit;
    logic          spill;
    logic          do_write;
    logic [7:0]    n_data;
    logic [1:0]    n_status;

    assign accept   = start && !busy;
    assign fill_c   = CW'(r_fill);
    assign in_off_c = CW'(i_read_offset);

    always_comb begin
        if (i_kind == bbar_pkg::KIND_APPEND) begin
            a0_c = fill_c[CW-1:3];
        end else begin
            a0_c = in_off_c[CW-1:3];
        end
        a1_c = a0_c + BW'(1);
    end

    bbar_mem #(
        .DEPTH (CAP_BYTES),
        .AW    (AW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wdata  (mem_wdata),
        .i_re     (accept),
        .i_raddr0 (AW'(a0_c)),
        .i_raddr1 (AW'(a1_c)),
        .o_rdata0 (rd0),
        .o_rdata1 (rd1)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= i_kind;
            r_value  <= i_value;
            r_count  <= i_bit_count;
            r_offset <= i_read_offset;
            r_a1     <= AW'(a1_c);
        end
        if (r_state == bbar_pkg::S_EXEC) begin
            r_hi <= merged[15:8];
        end
    end

    // execute: extract for reads, merge for appends
    always_comb begin
        off_c    = CW'(r_offset);
        cnt      = (r_count > 4'd8) ? 4'd8 : r_count;
        s_ap     = r_fill[2:0];
        win      = {rd1, rd0} >> r_offset[2:0];
        app      = bbar_pkg::bit_rev8(r_value) >> (4'd8 - cnt);
        keep     = rd0 & ~(8'hFF << s_ap);
        merged   = {8'h00, keep} | ({8'h00, app} << s_ap);
        app_fit  = (fill_c + CW'(cnt)) <= CAP_BITS;
        spill    = ({1'b0, s_ap} + cnt) > 4'd8;
        do_write = 1'b0;
        n_data   = 8'h00;
        n_status = bbar_pkg::STATUS_OK;
        n_fill   = r_fill;
        unique case (r_kind)
            bbar_pkg::KIND_APPEND: begin
                if (app_fit) begin
                    do_write = cnt != 4'd0;
                    n_fill   = r_fill + FW'(cnt);
                end else begin
                    n_status = bbar_pkg::STATUS_FULL;
                end
            end
            bbar_pkg::KIND_RD_BIT: begin
                if (off_c < fill_c) begin
                    n_data = {7'b0, win[0]};
                end else begin
                    n_status = bbar_pkg::STATUS_RANGE;
                end
            end
            bbar_pkg::KIND_RD_BYTE: begin
                if ((off_c + CW'(7)) < fill_c) begin
                    n_data = bbar_pkg::bit_rev8(win[7:0]);
                end else begin
                    n_status = bbar_pkg::STATUS_RANGE;
                end
            end
            default: begin
                n_data = 8'h00;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bbar_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = bbar_pkg::S_EXEC;
                end
            end
            bbar_pkg::S_EXEC: begin
                if (do_write && spill) begin
                    n_state = bbar_pkg::S_WR2;
                end else begin
                    n_state = bbar_pkg::S_IDLE;
                end
            end
            bbar_pkg::S_WR2: begin
                n_state = bbar_pkg::S_IDLE;
            end
            default: begin
                n_state = bbar_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        busy      = r_state != bbar_pkg::S_IDLE;
        mem_we    = 1'b0;
        mem_waddr = AW'(fill_c[CW-1:3]);
        mem_wdata = merged[7:0];
        unique case (r_state)
            bbar_pkg::S_IDLE: begin
                mem_we = 1'b0;
            end
            bbar_pkg::S_EXEC: begin
                mem_we = do_write;
            end
            bbar_pkg::S_WR2: begin
                mem_we    = 1'b1;
                mem_waddr = r_a1;
                mem_wdata = r_hi;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbar_pkg::S_IDLE;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= r_state == bbar_pkg::S_EXEC;
            if (r_state == bbar_pkg::S_EXEC) begin
                r_fill <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bbar_pkg::S_EXEC) begin
            r_read_data <= n_data;
            r_status    <= n_status;
            r_fill_bits <= 12'(n_fill);
        end
    end

    assign o_valid     = r_valid;
    assign o_read_data = r_read_data;
    assign o_status    = r_status;
    assign o_fill_bits = r_fill_bits;

endmodule
`default_nettype wire

// File: hdl/bbar_mem.sv
// Byte store: one write port, two registered read ports.
`default_nettype none
module bbar_mem #(
    parameter int DEPTH = bbar_pkg::CAP_BYTES_DEF,
    parameter int AW    = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr0,
    input  wire logic [AW-1:0] i_raddr1,
    output logic      [7:0]    o_rdata0,
    output logic      [7:0]    o_rdata1
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata0;
    logic [7:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata0 <= r_mem[i_raddr0];
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule
`default_nettype wire

// File: hdl/bbar_checker.sv
// Port-level checker for the bit buffer append/read unit, bound to the top level.
`default_nettype none
module bbar_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [7:0]  o_read_data,
    input wire logic [1:0]  o_status
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not make the unit busy");

    a_valid_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a word in progress");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_err_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == bbar_pkg::STATUS_RANGE || o_status == bbar_pkg::STATUS_FULL)
            |-> o_read_data == 8'h00)
        else $error("error result carries nonzero data");

endmodule

bind bit_buffer_append_read_unit bbar_checker u_bbar_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_read_data (o_read_data),
    .o_status    (o_status)
);
`default_nettype wire

// File: tb/sv/bit_buffer_append_read_unit_test.sv
// Self-checking testbench for the bit buffer append/read unit.
`default_nettype none
module bit_buffer_append_read_unit_test;

    localparam int CAP_BYTES = bbar_pkg::CAP_BYTES_DEF;
    localparam int CAP_BITS = CAP_BYTES * 8;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [7:0]  data;
        logic [1:0]  status;
        logic [11:0] fill;
    } t_bit_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_kind;
    logic [7:0]  i_value;
    logic [3:0]  i_bit_count;
    logic [10:0] i_read_offset;
    logic        o_valid;
    logic [7:0]  o_read_data;
    logic [1:0]  o_status;
    logic [11:0] o_fill_bits;

    logic [7:0]  stored_bytes [CAP_BYTES];
    int          stored_fill;
    t_bit_result pending_results [$];
    int          mismatch_count;
    int          stall_cycles;
    bit          idle_on;

    bit_buffer_append_read_unit #(.CAP_BYTES(CAP_BYTES)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .i_bit_count   (i_bit_count),
        .i_read_offset (i_read_offset),
        .o_valid       (o_valid),
        .o_read_data   (o_read_data),
        .o_status      (o_status),
        .o_fill_bits   (o_fill_bits)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic stored_bit_at(int pos);
        if ((pos >> 3) >= CAP_BYTES) begin
            return 1'b0;
        end
        return stored_bytes[pos >> 3][pos % 8];
    endfunction

    function automatic t_bit_result bits_apply(logic [1:0] kind, logic [7:0] value,
                                               logic [3:0] count, logic [10:0] offset);
        t_bit_result r;
        int n;
        r = '0;
        case (kind)
            bbar_pkg::KIND_APPEND: begin
                n = (count > 4'd8) ? 8 : int'(count);
                if (stored_fill + n > CAP_BITS) begin
                    r.status = bbar_pkg::STATUS_FULL;
                end else begin
                    for (int i = n; i > 0; i--) begin
                        stored_bytes[stored_fill >> 3][stored_fill % 8] = value[i - 1];
                        stored_fill++;
                    end
                end
            end
            bbar_pkg::KIND_RD_BIT: begin
                if (int'(offset) < stored_fill) begin
                    r.data = {7'd0, stored_bit_at(int'(offset))};
                end else begin
                    r.status = bbar_pkg::STATUS_RANGE;
                end
            end
            bbar_pkg::KIND_RD_BYTE: begin
                if (int'(offset) + 7 < stored_fill) begin
                    for (int i = 0; i < 8; i++) begin
                        r.data = {r.data[6:0], stored_bit_at(int'(offset) + i)};
                    end
                end else begin
                    r.status = bbar_pkg::STATUS_RANGE;
                end
            end
            default: ;
        endcase
        r.fill = stored_fill[11:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    task automatic send_word(logic [1:0] w_kind, logic [7:0] w_value,
                             logic [3:0] w_count, logic [10:0] w_offset);
        @(negedge i_clk);
        start         <= 1'b1;
        i_kind        <= w_kind;
        i_value       <= w_value;
        i_bit_count   <= w_count;
        i_read_offset <= w_offset;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        pending_results.push_back(bits_apply(w_kind, w_value, w_count, w_offset));
    endtask

    task automatic sender_gap();
        int n;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 10);
            @(negedge i_clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic random_word();
        int sel;
        int pick;
        logic [10:0] off;
        sel = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        off = 11'($urandom_range(0, 2047));
        if (sel < 25) begin
            send_word(bbar_pkg::KIND_APPEND, 8'($urandom), 4'($urandom_range(0, 15)), off);
        end else if (sel < 60) begin
            if (pick < 75 && stored_fill >= 1) begin
                off = 11'($urandom_range(0, stored_fill - 1));
            end else if (pick < 90) begin
                off = 11'((stored_fill > 2047 ? 2047 : stored_fill) - $urandom_range(0, 1));
            end
            send_word(bbar_pkg::KIND_RD_BIT, 8'($urandom), 4'($urandom), off);
        end else if (sel < 95) begin
            if (pick < 75 && stored_fill >= 8) begin
                off = 11'($urandom_range(0, stored_fill - 8));
            end else if (pick < 90 && stored_fill >= 8) begin
                off = 11'(stored_fill - 8 + $urandom_range(0, 1));
            end
            send_word(bbar_pkg::KIND_RD_BYTE, 8'($urandom), 4'($urandom), off);
        end else begin
            send_word(KIND_UNUSED, 8'($urandom), 4'($urandom), off);
        end
    endtask

    task automatic test_directed_cases();
        send_word(bbar_pkg::KIND_RD_BIT,  8'h00, 4'd0,  11'd0);
        send_word(bbar_pkg::KIND_RD_BYTE, 8'h00, 4'd0,  11'd0);
        send_word(bbar_pkg::KIND_APPEND,  8'hFF, 4'd0,  11'd0);
        send_word(bbar_pkg::KIND_APPEND,  8'hA5, 4'd8,  11'd0);
        send_word(bbar_pkg::KIND_APPEND,  8'h3C, 4'd15, 11'h7FF);
        send_word(bbar_pkg::KIND_APPEND,  8'h01, 4'd1,  11'd0);
        send_word(bbar_pkg::KIND_APPEND,  8'h05, 4'd3,  11'd0);
        send_word(bbar_pkg::KIND_APPEND,  8'h7F, 4'd7,  11'd0);
        send_word(bbar_pkg::KIND_APPEND,  8'h00, 4'd9,  11'd0);
        send_word(bbar_pkg::KIND_APPEND,  8'hF0, 4'd4,  11'd0);
        send_word(bbar_pkg::KIND_RD_BIT,  8'h00, 4'd0,  11'd0);
        send_word(bbar_pkg::KIND_RD_BIT,  8'h00, 4'd0,  11'd38);
        send_word(bbar_pkg::KIND_RD_BIT,  8'h00, 4'd0,  11'd39);
        send_word(bbar_pkg::KIND_RD_BYTE, 8'h00, 4'd0,  11'd0);
        send_word(bbar_pkg::KIND_RD_BYTE, 8'h00, 4'd0,  11'd3);
        send_word(bbar_pkg::KIND_RD_BYTE, 8'h00, 4'd0,  11'd31);
        send_word(bbar_pkg::KIND_RD_BYTE, 8'h00, 4'd0,  11'd32);
        send_word(bbar_pkg::KIND_RD_BIT,  8'h00, 4'd0,  11'd2047);
        send_word(bbar_pkg::KIND_RD_BYTE, 8'hFF, 4'd15, 11'd2047);
        send_word(KIND_UNUSED,            8'hFF, 4'd15, 11'd2047);
        send_word(KIND_UNUSED,            8'h00, 4'd0,  11'd0);
    endtask

    task automatic test_random_traffic(int count);
        for (int i = 0; i < count; i++) begin
            idle_on = ((i / 150) % 3) != 2;
            if (i % 400 == 399) begin
                wait_drained();
            end
            random_word();
            sender_gap();
        end
    endtask

    task automatic test_drain_and_resume();
        idle_on = 1'b1;
        repeat (20) begin
            random_word();
        end
        wait_drained();
        repeat (20) begin
            random_word();
            sender_gap();
        end
    endtask

    task automatic test_fill_to_capacity();
        int rem;
        idle_on = 1'b1;
        while (CAP_BITS - stored_fill >= 16) begin
            send_word(bbar_pkg::KIND_APPEND, 8'($urandom), 4'($urandom_range(1, 15)),
                      11'($urandom));
            sender_gap();
        end
        while (CAP_BITS - stored_fill >= 8) begin
            send_word(bbar_pkg::KIND_APPEND, 8'($urandom), 4'd8, 11'($urandom));
        end
        rem = CAP_BITS - stored_fill;
        send_word(bbar_pkg::KIND_APPEND, 8'($urandom), 4'd8, 11'd0);
        if (rem > 0) begin
            send_word(bbar_pkg::KIND_APPEND, 8'($urandom), 4'(rem + 1), 11'd0);
            send_word(bbar_pkg::KIND_APPEND, 8'($urandom), 4'(rem), 11'd0);
        end
        send_word(bbar_pkg::KIND_APPEND, 8'hFF, 4'd1,  11'd0);
        send_word(bbar_pkg::KIND_APPEND, 8'hFF, 4'd0,  11'd0);
        send_word(bbar_pkg::KIND_APPEND, 8'hFF, 4'd15, 11'd0);
    endtask

    task automatic test_reads_at_top();
        idle_on = 1'b0;
        send_word(bbar_pkg::KIND_RD_BIT,  8'h00, 4'd0, 11'd2047);
        send_word(bbar_pkg::KIND_RD_BIT,  8'h00, 4'd0, 11'd2040);
        send_word(bbar_pkg::KIND_RD_BYTE, 8'h00, 4'd0, 11'd2040);
        send_word(bbar_pkg::KIND_RD_BYTE, 8'h00, 4'd0, 11'd2041);
        send_word(bbar_pkg::KIND_RD_BYTE, 8'h00, 4'd0, 11'd2047);
        send_word(bbar_pkg::KIND_RD_BYTE, 8'h00, 4'd0, 11'd0);
        repeat (150) begin
            random_word();
        end
    endtask

    always @(posedge i_clk) begin
        t_bit_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", int'(o_read_data), 0);
            end else begin
                want = pending_results.pop_front();
                if (o_read_data !== want.data) begin
                    report_mismatch("read_data", o_read_data, want.data);
                end
                if (o_status !== want.status) begin
                    report_mismatch("status", o_status, want.status);
                end
                if (o_fill_bits !== want.fill) begin
                    report_mismatch("fill_bits", o_fill_bits, want.fill);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("bit_buffer_append_read_unit_test: done, errors");
            $finish;
        end
    end

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_kind         = bbar_pkg::KIND_APPEND;
        i_value        = 8'd0;
        i_bit_count    = 4'd0;
        i_read_offset  = 11'd0;
        stored_fill    = 0;
        mismatch_count = 0;
        stall_cycles   = 0;
        idle_on        = 1'b1;
        for (int i = 0; i < CAP_BYTES; i++) begin
            stored_bytes[i] = 8'd0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_traffic(1570);
        test_drain_and_resume();
        test_fill_to_capacity();
        test_reads_at_top();

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("bit_buffer_append_read_unit_test: done, clean");
        end else begin
            $display("bit_buffer_append_read_unit_test: done, errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
